// ----- rtl/stcd_pkg.sv -----
// Shared constants for the seconds-to-calendar-date pipeline.
// Reciprocal multipliers, day-number constants and month tables.
// No dependencies.
package stcd_pkg;

   // Number of register stages from the request transfer to the response register.
   localparam int STAGES = 9;

   // Offset register reset value: eight hours.
   localparam logic signed [16:0] ZONE_RESET = 17'sd28800;

   // Seconds per day is 128 * 675. The quotient by 675 uses an exact
   // reciprocal multiply for any 26-bit dividend: ceil(2^36 / 675).
   localparam int          DAY_SHIFT  = 36;
   localparam logic [26:0] DAY_RECIP  = 27'd101806633;
   localparam logic [9:0]  DAY_DIV    = 10'd675;

   // Day number of 1904-01-01 and the Gregorian century correction.
   // alpha = floor((4a - 7468865) / 146097) is 15 at the epoch and
   // steps up at the day numbers below; only the first is reachable.
   localparam logic [21:0] EPOCH_DAY  = 22'd2416481;
   localparam logic [4:0]  ALPHA_BASE = 5'd15;
   localparam logic [21:0] ALPHA_16   = 22'd2451605;
   localparam logic [21:0] ALPHA_17   = 22'd2488129;
   localparam logic [21:0] B_OFFSET   = 22'd1525;

   // c = floor((20b - 2442) / 7305), exact reciprocal ceil(2^39 / 7305).
   localparam logic [26:0] C_BIAS     = 27'd2442;
   localparam int          C_SHIFT    = 39;
   localparam logic [26:0] C_RECIP    = 27'd75257470;

   // Hours: tod / 3600 = (tod / 16) / 225, reciprocal ceil(2^21 / 225).
   localparam int          HOUR_SHIFT = 21;
   localparam logic [13:0] HOUR_RECIP = 14'd9321;
   localparam logic [11:0] SEC_PER_HR = 12'd3600;

   // Minutes: rs / 60 = (rs / 4) / 15, reciprocal ceil(2^14 / 15).
   localparam int          MIN_SHIFT  = 14;
   localparam logic [10:0] MIN_RECIP  = 11'd1093;
   localparam logic [11:0] SEC_PER_MN = 12'd60;

   // Year bases for the final step of the Julian-day method.
   localparam logic [12:0] YEAR_BASE_LATE  = 13'd4716;
   localparam logic [12:0] YEAR_BASE_EARLY = 13'd4715;

   // Smallest d with floor(d / 30.6001) >= k, for k = 1 .. 15.
   localparam logic [8:0] E_THRESH [15] = '{
      9'd31,  9'd62,  9'd92,  9'd123, 9'd154, 9'd184, 9'd215, 9'd245,
      9'd276, 9'd307, 9'd337, 9'd368, 9'd398, 9'd429, 9'd460
   };

   // floor(30.6001 * e), for e = 0 .. 15.
   localparam logic [8:0] DAY_BASE [16] = '{
      9'd0,   9'd30,  9'd61,  9'd91,  9'd122, 9'd153, 9'd183, 9'd214,
      9'd244, 9'd275, 9'd306, 9'd336, 9'd367, 9'd397, 9'd428, 9'd459
   };

endpackage

// ----- rtl/seconds_to_calendar_date.sv -----
// Top level of the seconds-to-calendar-date converter: a nine-stage pipeline.
// Depends on stcd_pkg for its constants and month tables.
//
// Usage
//   Request channel: req_valid / req_ready with req_epoch_seconds, an
//   unsigned count of seconds since 1904-01-01 00:00:00. Every request
//   transfer yields exactly one response transfer, in order.
//   Response channel: rsp_valid / rsp_ready with year, month, day_of_month,
//   hour, minute and second of the local date and time.
//   Configuration: csr_valid / csr_ready with csr_zone_offset_seconds, a
//   signed offset added to the count before conversion. csr_ready is always
//   high; write only while no request is in flight.
//   Throughput: one request per cycle unless a stall holds the pipeline,
//   which has nine register stages.
//   Reset: empties the pipeline and sets the offset to eight hours.
//   Stall: when rsp_ready is low the response register holds; empty stages
//   upstream still fill, and req_ready falls only once every stage is full.
//   Counts that fall before the epoch after the offset clamp to 1904-01-01.
module seconds_to_calendar_date
   import stcd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [31:0]        req_epoch_seconds,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [10:0]        rsp_year,
   output logic [3:0]         rsp_month,
   output logic [4:0]         rsp_day_of_month,
   output logic [4:0]         rsp_hour,
   output logic [5:0]         rsp_minute,
   output logic [5:0]         rsp_second,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic signed [16:0] csr_zone_offset_seconds
);

   // Zone offset register. Writes are always taken.
   logic signed [16:0] zone_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_ff <= ZONE_RESET;
      end else if (csr_valid) begin
         zone_ff <= csr_zone_offset_seconds;
      end
   end

   // Stage valid bits and load enables. A stage loads when it is empty or
   // when the stage after it moves, so bubbles collapse under a stall.
   logic [STAGES-1:0] v_ff;
   logic [STAGES-1:0] en;

   always_comb begin
      en[STAGES-1] = !v_ff[STAGES-1] || rsp_ready;
      for (int i = STAGES - 2; i >= 0; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = v_ff[STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= req_valid;
         end
         for (int i = 1; i < STAGES; i++) begin
            if (en[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
      end
   end

   // Stage 1: apply the offset and clamp negative sums to the epoch.
   logic [33:0] s1_total;
   logic [32:0] s1_t_in;
   logic [32:0] s1_t_ff;

   always_comb begin
      s1_total = {2'b00, req_epoch_seconds} + {{17{zone_ff[16]}}, zone_ff};
      s1_t_in  = s1_total[33] ? '0 : s1_total[32:0];
   end

   // Stage 2: whole days, as (t / 128) / 675 by reciprocal multiply.
   logic [52:0] s2_prod;
   logic [15:0] s2_days_in;
   logic [15:0] s2_days_ff;
   logic [32:0] s2_t_ff;

   always_comb begin
      s2_prod    = 53'(s1_t_ff[32:7]) * 53'(DAY_RECIP);
      s2_days_in = s2_prod[DAY_SHIFT+15:DAY_SHIFT];
   end

   // Stage 3: seconds into the day and the day number.
   logic [25:0] s3_part;
   logic [16:0] s3_tod_in;
   logic [21:0] s3_a_in;
   logic [16:0] s3_tod_ff;
   logic [21:0] s3_a_ff;

   always_comb begin
      s3_part   = s2_t_ff[32:7] - 26'(s2_days_ff) * 26'(DAY_DIV);
      s3_tod_in = {s3_part[9:0], s2_t_ff[6:0]};
      s3_a_in   = EPOCH_DAY + 22'(s2_days_ff);
   end

   // Stage 4: Gregorian correction into b, and the hour.
   logic [4:0]  s4_alpha;
   logic [21:0] s4_b_in;
   logic [26:0] s4_hprod;
   logic [4:0]  s4_hour_in;
   logic [21:0] s4_b_ff;
   logic [16:0] s4_tod_ff;
   logic [4:0]  s4_hour_ff;

   always_comb begin
      s4_alpha   = ALPHA_BASE + 5'(s3_a_ff >= ALPHA_16) + 5'(s3_a_ff >= ALPHA_17);
      s4_b_in    = s3_a_ff + B_OFFSET + 22'(s4_alpha - (s4_alpha >> 2));
      s4_hprod   = 27'(s3_tod_ff[16:4]) * 27'(HOUR_RECIP);
      s4_hour_in = s4_hprod[HOUR_SHIFT+4:HOUR_SHIFT];
   end

   // Stage 5: dividend for the year count, and seconds into the hour.
   logic [26:0] s5_n_wide;
   logic [25:0] s5_n_in;
   logic [11:0] s5_rs_in;
   logic [25:0] s5_n_ff;
   logic [21:0] s5_b_ff;
   logic [11:0] s5_rs_ff;
   logic [4:0]  s5_hour_ff;

   always_comb begin
      s5_n_wide = 27'(s4_b_ff) * 27'd20 - C_BIAS;
      s5_n_in   = s5_n_wide[25:0];
      s5_rs_in  = 12'(s4_tod_ff) - 12'(s4_hour_ff) * SEC_PER_HR;
   end

   // Stage 6: the count c by reciprocal multiply, and the minute.
   logic [52:0] s6_cprod;
   logic [12:0] s6_c_in;
   logic [20:0] s6_mprod;
   logic [5:0]  s6_minute_in;
   logic [12:0] s6_c_ff;
   logic [21:0] s6_b_ff;
   logic [11:0] s6_rs_ff;
   logic [4:0]  s6_hour_ff;
   logic [5:0]  s6_minute_ff;

   always_comb begin
      s6_cprod     = 53'(s5_n_ff) * 53'(C_RECIP);
      s6_c_in      = s6_cprod[C_SHIFT+12:C_SHIFT];
      s6_mprod     = 21'(s5_rs_ff[11:2]) * 21'(MIN_RECIP);
      s6_minute_in = s6_mprod[MIN_SHIFT+5:MIN_SHIFT];
   end

   // Stage 7: day within the shifted year, and the second.
   logic [23:0] s7_yprod;
   logic [21:0] s7_dwide;
   logic [8:0]  s7_d_in;
   logic [11:0] s7_sec_wide;
   logic [8:0]  s7_d_ff;
   logic [12:0] s7_c_ff;
   logic [4:0]  s7_hour_ff;
   logic [5:0]  s7_minute_ff;
   logic [5:0]  s7_second_ff;

   always_comb begin
      s7_yprod    = 24'(s6_c_ff) * 24'd1461;
      s7_dwide    = s6_b_ff - s7_yprod[23:2];
      s7_d_in     = s7_dwide[8:0];
      s7_sec_wide = s6_rs_ff - 12'(s6_minute_ff) * SEC_PER_MN;
   end

   // Stage 8: month index e as a count of threshold compares.
   logic [3:0]  s8_e_in;
   logic [3:0]  s8_e_ff;
   logic [8:0]  s8_d_ff;
   logic [12:0] s8_c_ff;
   logic [4:0]  s8_hour_ff;
   logic [5:0]  s8_minute_ff;
   logic [5:0]  s8_second_ff;

   always_comb begin
      s8_e_in = '0;
      for (int k = 0; k < 15; k++) begin
         s8_e_in = s8_e_in + 4'(s7_d_ff >= E_THRESH[k]);
      end
   end

   // Stage 9: day of month, month and year into the response register.
   logic [8:0]  s9_dom_wide;
   logic [3:0]  s9_month_in;
   logic [12:0] s9_year_wide;

   always_comb begin
      s9_dom_wide  = s8_d_ff - DAY_BASE[s8_e_ff];
      s9_month_in  = (s8_e_ff < 4'd14) ? s8_e_ff - 4'd1 : s8_e_ff - 4'd13;
      s9_year_wide = (s9_month_in > 4'd2) ? s8_c_ff - YEAR_BASE_LATE
                                          : s8_c_ff - YEAR_BASE_EARLY;
   end

   // Payload registers; only the valid bits are reset.
   always_ff @(posedge clock) begin
      if (en[0]) begin
         s1_t_ff <= s1_t_in;
      end
      if (en[1]) begin
         s2_t_ff    <= s1_t_ff;
         s2_days_ff <= s2_days_in;
      end
      if (en[2]) begin
         s3_tod_ff <= s3_tod_in;
         s3_a_ff   <= s3_a_in;
      end
      if (en[3]) begin
         s4_b_ff    <= s4_b_in;
         s4_tod_ff  <= s3_tod_ff;
         s4_hour_ff <= s4_hour_in;
      end
      if (en[4]) begin
         s5_n_ff    <= s5_n_in;
         s5_b_ff    <= s4_b_ff;
         s5_rs_ff   <= s5_rs_in;
         s5_hour_ff <= s4_hour_ff;
      end
      if (en[5]) begin
         s6_c_ff      <= s6_c_in;
         s6_b_ff      <= s5_b_ff;
         s6_rs_ff     <= s5_rs_ff;
         s6_hour_ff   <= s5_hour_ff;
         s6_minute_ff <= s6_minute_in;
      end
      if (en[6]) begin
         s7_d_ff      <= s7_d_in;
         s7_c_ff      <= s6_c_ff;
         s7_hour_ff   <= s6_hour_ff;
         s7_minute_ff <= s6_minute_ff;
         s7_second_ff <= s7_sec_wide[5:0];
      end
      if (en[7]) begin
         s8_e_ff      <= s8_e_in;
         s8_d_ff      <= s7_d_ff;
         s8_c_ff      <= s7_c_ff;
         s8_hour_ff   <= s7_hour_ff;
         s8_minute_ff <= s7_minute_ff;
         s8_second_ff <= s7_second_ff;
      end
      if (en[8]) begin
         rsp_year         <= s9_year_wide[10:0];
         rsp_month        <= s9_month_in;
         rsp_day_of_month <= s9_dom_wide[4:0];
         rsp_hour         <= s8_hour_ff;
         rsp_minute       <= s8_minute_ff;
         rsp_second       <= s8_second_ff;
      end
   end

   // The request side only stalls once every stage holds an item.
   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (&v_ff))
      else $error("req_ready low while a pipeline stage is empty");

   // Time of day fields stay in range on every response.
   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hour < 5'd24) && (rsp_minute < 6'd60) && (rsp_second < 6'd60))
      else $error("time of day out of range");

   // Month and day of month stay in range on every response.
   a_date_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_month >= 4'd1) && (rsp_month <= 4'd12)
                    && (rsp_day_of_month >= 5'd1) && (rsp_day_of_month <= 5'd31))
      else $error("month or day of month out of range");

   // Years stay between the epoch year, 1904, and 2041.
   a_year_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_year >= 11'd1904) && (rsp_year <= 11'd2041))
      else $error("year out of range");

endmodule
